@@ hdl/eight_bit_minifloat_cpu_unit_macros.svh @@
// assertion macros for the eight bit minifloat cpu unit
`ifndef EIGHT_BIT_MINIFLOAT_CPU_UNIT_MACROS_SVH
`define EIGHT_BIT_MINIFLOAT_CPU_UNIT_MACROS_SVH

// same-cycle implication, checked on i_clk, off while i_rst_n is low
`define EMFC_CHK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk, off while i_rst_n is low
`define EMFC_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/emfc_pkg.sv @@
// shared types, codes and minifloat helpers for the minifloat cpu
package emfc_pkg;

    localparam int REG_COUNT = 16;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int MF_SUM_W  = 13;

    localparam logic [2:0] REQ_STEP   = 3'd0;
    localparam logic [2:0] REQ_WR_MEM = 3'd1;
    localparam logic [2:0] REQ_RD_MEM = 3'd2;
    localparam logic [2:0] REQ_WR_REG = 3'd3;
    localparam logic [2:0] REQ_RD_REG = 3'd4;
    localparam logic [2:0] REQ_SET_PC = 3'd5;

    localparam logic [3:0] OP_ILLEGAL = 4'h0;
    localparam logic [3:0] OP_LOAD    = 4'h1;
    localparam logic [3:0] OP_LDI     = 4'h2;
    localparam logic [3:0] OP_STORE   = 4'h3;
    localparam logic [3:0] OP_MOVE    = 4'h4;
    localparam logic [3:0] OP_ADD     = 4'h5;
    localparam logic [3:0] OP_ADDF    = 4'h6;
    localparam logic [3:0] OP_OR      = 4'h7;
    localparam logic [3:0] OP_AND     = 4'h8;
    localparam logic [3:0] OP_XOR     = 4'h9;
    localparam logic [3:0] OP_ROR     = 4'hA;
    localparam logic [3:0] OP_JEQ     = 4'hB;
    localparam logic [3:0] OP_HALT    = 4'hC;
    localparam logic [3:0] OP_LDIND   = 4'hD;
    localparam logic [3:0] OP_STIND   = 4'hE;
    localparam logic [3:0] OP_JLT     = 4'hF;

    typedef struct packed {
        logic [3:0]                 op;
        logic [7:0]                 lo;
        logic [7:0]                 rr;
        logic [7:0]                 rs;
        logic [7:0]                 rt;
        logic [7:0]                 md;
        logic signed [MF_SUM_W-1:0] fsum;
    } t_alu_in;

    // signed value in units of 2^-3
    function automatic logic signed [MF_SUM_W-1:0] mf_value(input logic [7:0] v);
        logic [10:0]               mag;
        logic signed [MF_SUM_W-1:0] sv;
        mag = 11'({1'b1, v[2:0]}) << v[6:4];
        sv  = $signed({2'b00, mag});
        return v[7] ? -sv : sv;
    endfunction

    // normalize, truncate and saturate a sum back to minifloat
    function automatic logic [7:0] mf_pack(input logic signed [MF_SUM_W-1:0] s);
        logic                  sign;
        logic [MF_SUM_W-1:0]   neg;
        logic [11:0]           mag;
        logic [11:0]           sh;
        logic [3:0]            p;
        logic                  any;
        logic [3:0]            e;
        sign = s[MF_SUM_W-1];
        neg  = -s;
        mag  = sign ? neg[11:0] : s[11:0];
        p    = 4'd0;
        any  = 1'b0;
        for (int i = 0; i < 12; i++) begin
            if (mag[i]) begin
                p   = 4'(i);
                any = 1'b1;
            end
        end
        e  = p - 4'd3;
        sh = mag >> e;
        if (!any || p < 4'd3) begin
            return 8'h00;
        end else if (e > 4'd7) begin
            return {sign, 7'h7F};
        end else begin
            return {sign, e[2:0], 1'b1, sh[2:0]};
        end
    endfunction

endpackage

@@ hdl/emfc_ram.sv @@
// generic single write, single read ram with registered read data
module emfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/emfc_alu.sv @@
// result byte of a register-writing instruction
module emfc_alu (
    input  emfc_pkg::t_alu_in i_ops,
    output logic [7:0]        o_res
);

    logic [15:0] rot;

    assign rot = {i_ops.rr, i_ops.rr} >> i_ops.lo[2:0];

    always_comb begin
        case (i_ops.op)
            emfc_pkg::OP_LOAD:  o_res = i_ops.md;
            emfc_pkg::OP_LDI:   o_res = i_ops.lo;
            emfc_pkg::OP_MOVE:  o_res = i_ops.rs;
            emfc_pkg::OP_ADD:   o_res = i_ops.rs + i_ops.rt;
            emfc_pkg::OP_ADDF:  o_res = emfc_pkg::mf_pack(i_ops.fsum);
            emfc_pkg::OP_OR:    o_res = i_ops.rs | i_ops.rt;
            emfc_pkg::OP_AND:   o_res = i_ops.rs & i_ops.rt;
            emfc_pkg::OP_XOR:   o_res = i_ops.rs ^ i_ops.rt;
            emfc_pkg::OP_ROR:   o_res = rot[7:0];
            emfc_pkg::OP_LDIND: o_res = i_ops.md;
            default:            o_res = i_ops.rr;
        endcase
    end

endmodule

@@ hdl/eight_bit_minifloat_cpu_unit.sv @@
// top level of the eight bit minifloat cpu: sequencer over memory and register file
//
//   channel | dir | handshake               | word
//   in      | in  | i_in_valid / o_in_stall  | i_req_type, i_addr, i_data
//   out     | out | o_out_valid / i_out_stall| o_read_data, o_pc_now, o_halted, o_illegal
//
// a step passes through F1, F2, F3, F4 for the indirect load only, then WB: two fetch reads,
// register reads and one data access on the single memory port, then write back
// host reads pass through ST_HWAIT before ST_WB, other host requests go straight to ST_WB
// after reset a clearing pass over all MEM_BYTES addresses zeroes memory and registers
// while the input stays stalled
// one input word and one output word are buffered, so a new word enters while
// a result waits for the output stall to drop
`include "eight_bit_minifloat_cpu_unit_macros.svh"

module eight_bit_minifloat_cpu_unit #(
    parameter int MEM_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_addr,
    input  logic [7:0] i_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic [7:0] o_pc_now,
    output logic       o_halted,
    output logic       o_illegal
);

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_F1    = 3'd1;
    localparam logic [2:0] ST_F2    = 3'd2;
    localparam logic [2:0] ST_F3    = 3'd3;
    localparam logic [2:0] ST_F4    = 3'd4;
    localparam logic [2:0] ST_HWAIT = 3'd5;
    localparam logic [2:0] ST_WB    = 3'd6;

    // byte address modulo MEM_BYTES
    function automatic logic [AW-1:0] mem_idx(input logic [7:0] a);
        logic [13:0] x;
        x = 14'(a);
        for (int k = 4; k >= 0; k--) begin
            if (x >= 14'(MEM_BYTES << k)) begin
                x = x - 14'(MEM_BYTES << k);
            end
        end
        return x[AW-1:0];
    endfunction

    logic                 r_clr, n_clr;
    logic [AW-1:0]        r_clr_idx;
    logic                 r_in_vld, n_in_vld;
    logic [2:0]           r_in_req;
    logic [7:0]           r_in_addr;
    logic [7:0]           r_in_data;
    logic [2:0]           r_state, n_state;
    logic [2:0]           r_req;
    logic [7:0]           r_addr;
    logic [7:0]           r_data;
    logic [7:0]           r_pc, n_pc;
    logic [7:0]           r_hi, r_lo, r_rr, r_r0, r_rs, r_rt, r_md;
    logic signed [emfc_pkg::MF_SUM_W-1:0] r_fsum;
    logic                 r_out_vld, n_out_vld;
    logic [7:0]           r_out_rd;
    logic [7:0]           r_out_pc;
    logic                 r_out_halt;
    logic                 r_out_ill;

    logic                 start;
    logic                 accept;
    logic                 wb_go;
    logic [3:0]           op;
    logic                 is_step;
    logic                 taken;
    logic [7:0]           alu_res;
    emfc_pkg::t_alu_in    alu_ops;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [7:0]           mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [7:0]           mem_rdata;
    logic                 rf_we;
    logic [emfc_pkg::REG_AW-1:0] rf_waddr;
    logic [7:0]           rf_wdata;
    logic [emfc_pkg::REG_AW-1:0] rfa_raddr;
    logic [emfc_pkg::REG_AW-1:0] rfb_raddr;
    logic [7:0]           rfa_rdata;
    logic [7:0]           rfb_rdata;

    emfc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    emfc_ram #(.WIDTH(8), .DEPTH(emfc_pkg::REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rfa_raddr),
        .o_rdata (rfa_rdata)
    );

    emfc_ram #(.WIDTH(8), .DEPTH(emfc_pkg::REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rfb_raddr),
        .o_rdata (rfb_rdata)
    );

    assign op      = r_hi[7:4];
    assign is_step = (r_req == emfc_pkg::REQ_STEP);
    assign start   = (r_state == ST_IDLE) && r_in_vld && !r_clr;
    assign o_in_stall = r_clr || (r_in_vld && !start);
    assign accept  = i_in_valid && !o_in_stall;
    assign wb_go   = (r_state == ST_WB) && (!r_out_vld || !i_out_stall);
    assign taken   = ((op == emfc_pkg::OP_JEQ) && (r_rr == r_r0)) ||
                     ((op == emfc_pkg::OP_JLT) && (r_rr < r_r0));

    assign alu_ops.op   = op;
    assign alu_ops.lo   = r_lo;
    assign alu_ops.rr   = r_rr;
    assign alu_ops.rs   = r_rs;
    assign alu_ops.rt   = r_rt;
    assign alu_ops.md   = r_md;
    assign alu_ops.fsum = r_fsum;

    emfc_alu u_alu (
        .i_ops (alu_ops),
        .o_res (alu_res)
    );

    // memory and register file ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = mem_idx(r_addr);
        mem_wdata = r_data;
        mem_raddr = mem_idx(r_pc);
        rf_we     = 1'b0;
        rf_waddr  = r_hi[3:0];
        rf_wdata  = alu_res;
        rfa_raddr = r_in_addr[3:0];
        rfb_raddr = '0;
        if (r_clr) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = 8'h00;
            rf_we     = 1'b1;
            rf_waddr  = r_clr_idx[emfc_pkg::REG_AW-1:0];
            rf_wdata  = 8'h00;
        end
        case (r_state)
            ST_IDLE: begin
                if (r_in_req == emfc_pkg::REQ_RD_MEM) begin
                    mem_raddr = mem_idx(r_in_addr);
                end
            end
            ST_F1: begin
                mem_raddr = mem_idx(r_pc + 8'd1);
                rfa_raddr = mem_rdata[3:0];
            end
            ST_F2: begin
                mem_raddr = mem_idx(mem_rdata);
                rfa_raddr = mem_rdata[7:4];
                rfb_raddr = mem_rdata[3:0];
            end
            ST_F3: begin
                mem_raddr = mem_idx(rfb_rdata);
            end
            ST_WB: begin
                if (wb_go) begin
                    if (is_step) begin
                        if (op == emfc_pkg::OP_STORE) begin
                            mem_we    = 1'b1;
                            mem_waddr = mem_idx(r_lo);
                            mem_wdata = r_rr;
                        end else if (op == emfc_pkg::OP_STIND) begin
                            mem_we    = 1'b1;
                            mem_waddr = mem_idx(r_rt);
                            mem_wdata = r_rr;
                        end
                        if (op inside {emfc_pkg::OP_LOAD, emfc_pkg::OP_LDI,
                                       emfc_pkg::OP_ADD, emfc_pkg::OP_ADDF,
                                       emfc_pkg::OP_OR, emfc_pkg::OP_AND,
                                       emfc_pkg::OP_XOR, emfc_pkg::OP_ROR,
                                       emfc_pkg::OP_LDIND}) begin
                            rf_we = 1'b1;
                        end else if (op == emfc_pkg::OP_MOVE) begin
                            rf_we    = 1'b1;
                            rf_waddr = r_lo[3:0];
                        end
                    end else if (r_req == emfc_pkg::REQ_WR_MEM) begin
                        mem_we = 1'b1;
                    end else if (r_req == emfc_pkg::REQ_WR_REG) begin
                        rf_we    = 1'b1;
                        rf_waddr = r_addr[3:0];
                        rf_wdata = r_data;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer and handshake control
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_in_vld  = r_in_vld;
        n_out_vld = r_out_vld;
        n_pc      = r_pc;
        if (r_clr && r_clr_idx == AW'(MEM_BYTES - 1)) begin
            n_clr = 1'b0;
        end
        if (accept) begin
            n_in_vld = 1'b1;
        end else if (start) begin
            n_in_vld = 1'b0;
        end
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
        if (is_step) begin
            n_pc = taken ? r_lo : r_pc + 8'd2;
        end else if (r_req == emfc_pkg::REQ_SET_PC) begin
            n_pc = r_addr;
        end
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (r_in_req)
                        emfc_pkg::REQ_STEP:   n_state = ST_F1;
                        emfc_pkg::REQ_RD_MEM: n_state = ST_HWAIT;
                        emfc_pkg::REQ_RD_REG: n_state = ST_HWAIT;
                        default:              n_state = ST_WB;
                    endcase
                end
            end
            ST_F1:    n_state = ST_F2;
            ST_F2:    n_state = ST_F3;
            ST_F3:    n_state = (op == emfc_pkg::OP_LDIND) ? ST_F4 : ST_WB;
            ST_F4:    n_state = ST_WB;
            ST_HWAIT: n_state = ST_WB;
            ST_WB: begin
                if (wb_go) begin
                    n_state   = ST_IDLE;
                    n_out_vld = 1'b1;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
            r_in_vld  <= 1'b0;
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_pc      <= 8'h00;
        end else begin
            r_clr     <= n_clr;
            r_clr_idx <= r_clr_idx + AW'(1);
            r_in_vld  <= n_in_vld;
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (wb_go) begin
                r_pc <= n_pc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_req  <= i_req_type;
            r_in_addr <= i_addr;
            r_in_data <= i_data;
        end
        if (start) begin
            r_req  <= r_in_req;
            r_addr <= r_in_addr;
            r_data <= r_in_data;
        end
        case (r_state)
            ST_F1: r_hi <= mem_rdata;
            ST_F2: begin
                r_lo <= mem_rdata;
                r_rr <= rfa_rdata;
                r_r0 <= rfb_rdata;
            end
            ST_F3: begin
                r_rs   <= rfa_rdata;
                r_rt   <= rfb_rdata;
                r_md   <= mem_rdata;
                r_fsum <= emfc_pkg::mf_value(rfa_rdata) + emfc_pkg::mf_value(rfb_rdata);
            end
            ST_F4: r_md <= mem_rdata;
            ST_HWAIT: r_md <= (r_req == emfc_pkg::REQ_RD_REG) ? rfa_rdata : mem_rdata;
            default: begin
            end
        endcase
        if (wb_go) begin
            r_out_rd   <= ((r_req == emfc_pkg::REQ_RD_MEM) ||
                           (r_req == emfc_pkg::REQ_RD_REG)) ? r_md : 8'h00;
            r_out_pc   <= n_pc;
            r_out_halt <= is_step && ((op == emfc_pkg::OP_HALT) ||
                                      (op == emfc_pkg::OP_ILLEGAL));
            r_out_ill  <= is_step && (op == emfc_pkg::OP_ILLEGAL);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_read_data = r_out_rd;
    assign o_pc_now    = r_out_pc;
    assign o_halted    = r_out_halt;
    assign o_illegal   = r_out_ill;

    `EMFC_CHK_NOW(a_clr_quiet, r_clr, (r_state == ST_IDLE) && !o_out_valid, "busy during clear")
    `EMFC_CHK_NEXT(a_wb_hold, (r_state == ST_WB) && r_out_vld && i_out_stall, r_state == ST_WB, "result overwrote a stalled word")
    `EMFC_CHK_NEXT(a_idle_hold, (r_state == ST_IDLE) && !start, r_state == ST_IDLE, "left idle with no word")
    `EMFC_CHK_NOW(a_ill_halt, o_out_valid && o_illegal, o_halted, "illegal without halt")

endmodule

@@ tb/eight_bit_minifloat_cpu_unit_tb.sv @@
// self-checking testbench for the eight bit minifloat cpu unit with a shadow machine scoreboard
`timescale 1ns / 1ps

module eight_bit_minifloat_cpu_unit_tb;

    localparam logic [2:0] REQ_UNUSED_A = 3'd6;
    localparam logic [2:0] REQ_UNUSED_B = 3'd7;
    localparam int WORDS_TARGET = 900;
    localparam int CALM_FROM    = 1500;
    localparam int CALM_TO      = 3000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] pc_now;
        logic       halted;
        logic       illegal;
    } t_cpu_word;

    class cpu_shadow_board;
        logic [7:0] mem [256];
        logic [7:0] regs [16];
        logic [7:0] pc;
        t_cpu_word  pending_words [$];
        int         failures;

        function new();
            foreach (mem[i]) mem[i] = 8'h00;
            foreach (regs[i]) regs[i] = 8'h00;
            pc       = 8'h00;
            failures = 0;
        endfunction

        function logic [7:0] minifloat_sum(logic [7:0] a, logic [7:0] b);
            int   va;
            int   vb;
            int   total;
            int   mag;
            int   p;
            int   e;
            int   frac;
            logic sign;
            va = (8 + a[2:0]) << a[6:4];
            vb = (8 + b[2:0]) << b[6:4];
            if (a[7]) va = -va;
            if (b[7]) vb = -vb;
            total = va + vb;
            sign  = total < 0;
            mag   = sign ? -total : total;
            p     = -1;
            for (int i = 0; i < 16; i++) begin
                if (mag[i]) p = i;
            end
            if (p < 3) return 8'h00;
            e = p - 3;
            if (e > 7) return {sign, 7'h7F};
            frac = mag >> e;
            return {sign, 3'(e), 1'b1, frac[2:0]};
        endfunction

        function void run_instruction(output logic halted, output logic illegal);
            logic [7:0] hi;
            logic [7:0] lo;
            logic [7:0] next_addr;
            logic [7:0] x;
            logic [3:0] op;
            logic [3:0] rn;
            logic [3:0] sn;
            logic [3:0] tn;
            logic [15:0] doubled;
            next_addr = pc + 8'd1;
            hi        = mem[pc];
            lo        = mem[next_addr];
            op        = hi[7:4];
            rn        = hi[3:0];
            sn        = lo[7:4];
            tn        = lo[3:0];
            pc        = pc + 8'd2;
            halted    = 1'b0;
            illegal   = 1'b0;
            case (op)
                emfc_pkg::OP_LOAD:  regs[rn] = mem[lo];
                emfc_pkg::OP_LDI:   regs[rn] = lo;
                emfc_pkg::OP_STORE: mem[lo] = regs[rn];
                emfc_pkg::OP_MOVE:  regs[tn] = regs[sn];
                emfc_pkg::OP_ADD:   regs[rn] = regs[sn] + regs[tn];
                emfc_pkg::OP_ADDF:  regs[rn] = minifloat_sum(regs[sn], regs[tn]);
                emfc_pkg::OP_OR:    regs[rn] = regs[sn] | regs[tn];
                emfc_pkg::OP_AND:   regs[rn] = regs[sn] & regs[tn];
                emfc_pkg::OP_XOR:   regs[rn] = regs[sn] ^ regs[tn];
                emfc_pkg::OP_ROR: begin
                    x        = regs[rn];
                    doubled  = {x, x} >> lo[2:0];
                    regs[rn] = doubled[7:0];
                end
                emfc_pkg::OP_JEQ: begin
                    if (regs[rn] == regs[0]) pc = lo;
                end
                emfc_pkg::OP_HALT:  halted = 1'b1;
                emfc_pkg::OP_LDIND: regs[rn] = mem[regs[tn]];
                emfc_pkg::OP_STIND: mem[regs[tn]] = regs[rn];
                emfc_pkg::OP_JLT: begin
                    if (regs[rn] < regs[0]) pc = lo;
                end
                default: begin
                    halted  = 1'b1;
                    illegal = 1'b1;
                end
            endcase
        endfunction

        function void note_request(logic [2:0] req, logic [7:0] a, logic [7:0] d);
            t_cpu_word w;
            w = '0;
            case (req)
                emfc_pkg::REQ_STEP:   run_instruction(w.halted, w.illegal);
                emfc_pkg::REQ_WR_MEM: mem[a] = d;
                emfc_pkg::REQ_RD_MEM: w.read_data = mem[a];
                emfc_pkg::REQ_WR_REG: regs[a[3:0]] = d;
                emfc_pkg::REQ_RD_REG: w.read_data = regs[a[3:0]];
                emfc_pkg::REQ_SET_PC: pc = a;
                default: ;
            endcase
            w.pc_now = pc;
            pending_words.push_back(w);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_word(logic [7:0] rd, logic [7:0] pcn, logic h, logic il);
            t_cpu_word want;
            if (pending_words.size() == 0) begin
                $error("result word with no request outstanding");
                failures++;
                return;
            end
            want = pending_words.pop_front();
            compare_field("read_data", want.read_data, rd);
            compare_field("pc_now", want.pc_now, pcn);
            compare_field("halted", want.halted, h);
            compare_field("illegal", want.illegal, il);
        endfunction

        function int pending_count();
            return pending_words.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [2:0] i_req_type;
    logic [7:0] i_addr;
    logic [7:0] i_data;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_read_data;
    logic [7:0] o_pc_now;
    logic       o_halted;
    logic       o_illegal;

    cpu_shadow_board board;
    int cycle_count = 0;
    int words_sent  = 0;

    eight_bit_minifloat_cpu_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_addr      (i_addr),
        .i_data      (i_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_read_data (o_read_data),
        .o_pc_now    (o_pc_now),
        .o_halted    (o_halted),
        .o_illegal   (o_illegal)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic bit take_gap();
        return (cycle_count < CALM_FROM || cycle_count >= CALM_TO)
               && ($urandom_range(0, 99) < 25);
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= take_gap();
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_word(o_read_data, o_pc_now, o_halted, o_illegal);
        end
    end

    task automatic drive_request(input logic [2:0] req, input logic [7:0] a,
                                 input logic [7:0] d);
        while (take_gap()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_addr     <= a;
        i_data     <= d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_request(req, a, d);
        words_sent++;
    endtask

    // load a short program, seed registers, point the pc at it, run it and may read back registers or memory
    task automatic run_program_burst();
        logic [7:0] base;
        logic [7:0] at;
        logic [7:0] lo;
        logic [7:0] value;
        logic [3:0] op;
        int         len;
        base = 8'($urandom_range(0, 255));
        len  = $urandom_range(2, 8);
        for (int i = 0; i < len; i++) begin
            op = ($urandom_range(0, 19) == 0) ? emfc_pkg::OP_ILLEGAL
                                              : 4'($urandom_range(1, 15));
            lo = 8'($urandom_range(0, 255));
            if ((op == emfc_pkg::OP_JEQ || op == emfc_pkg::OP_JLT) && $urandom_range(0, 1)) begin
                lo = base + 8'(2 * $urandom_range(0, len - 1));
            end
            at = base + 8'(2 * i);
            drive_request(emfc_pkg::REQ_WR_MEM, at, {op, 4'($urandom_range(0, 15))});
            drive_request(emfc_pkg::REQ_WR_MEM, at + 8'd1, lo);
        end
        repeat ($urandom_range(1, 4)) begin
            value = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 3));
            drive_request(emfc_pkg::REQ_WR_REG, 8'($urandom_range(0, 255)), value);
        end
        drive_request(emfc_pkg::REQ_SET_PC, base, 8'($urandom_range(0, 255)));
        repeat (len + $urandom_range(0, 3)) begin
            drive_request(emfc_pkg::REQ_STEP, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 3)) begin
            drive_request($urandom_range(0, 1) ? emfc_pkg::REQ_RD_REG : emfc_pkg::REQ_RD_MEM,
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("** eight_bit_minifloat_cpu_unit: FAILED **");
        $finish;
    end

    initial begin
        board      = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = emfc_pkg::REQ_STEP;
        i_addr     = 8'h00;
        i_data     = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        drive_request(emfc_pkg::REQ_RD_REG, 8'h00, 8'h00);
        drive_request(emfc_pkg::REQ_RD_MEM, 8'hFF, 8'hFF);
        drive_request(emfc_pkg::REQ_STEP, 8'h00, 8'h00);
        // minifloat overflow, pc wrapping past the top of memory
        drive_request(emfc_pkg::REQ_WR_REG, 8'hFF, 8'h7F);
        drive_request(emfc_pkg::REQ_WR_REG, 8'h0E, 8'h7F);
        drive_request(emfc_pkg::REQ_WR_MEM, 8'hFE, {emfc_pkg::OP_ADDF, 4'hD});
        drive_request(emfc_pkg::REQ_WR_MEM, 8'hFF, 8'hEF);
        drive_request(emfc_pkg::REQ_SET_PC, 8'hFE, 8'h00);
        drive_request(emfc_pkg::REQ_STEP, 8'h00, 8'h00);
        drive_request(emfc_pkg::REQ_RD_REG, 8'h0D, 8'h00);
        // minifloat underflow with bit 3 set on an operand
        drive_request(emfc_pkg::REQ_WR_REG, 8'h01, 8'h09);
        drive_request(emfc_pkg::REQ_WR_REG, 8'h02, 8'h80);
        drive_request(emfc_pkg::REQ_WR_MEM, 8'h00, {emfc_pkg::OP_ADDF, 4'h3});
        drive_request(emfc_pkg::REQ_WR_MEM, 8'h01, 8'h12);
        drive_request(emfc_pkg::REQ_STEP, 8'hFF, 8'hFF);
        drive_request(emfc_pkg::REQ_RD_REG, 8'h03, 8'h00);
        // halt, then rotate by zero
        drive_request(emfc_pkg::REQ_WR_MEM, 8'h02, {emfc_pkg::OP_HALT, 4'h0});
        drive_request(emfc_pkg::REQ_STEP, 8'h00, 8'h00);
        drive_request(emfc_pkg::REQ_WR_MEM, 8'h04, {emfc_pkg::OP_ROR, 4'hF});
        drive_request(emfc_pkg::REQ_WR_MEM, 8'h05, 8'hF8);
        drive_request(emfc_pkg::REQ_STEP, 8'h00, 8'h00);
        drive_request(REQ_UNUSED_A, 8'hFF, 8'hFF);
        drive_request(REQ_UNUSED_B, 8'h00, 8'h00);

        while (words_sent < WORDS_TARGET) begin
            if ($urandom_range(0, 9) < 8) begin
                run_program_burst();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    drive_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)));
                end
            end
        end
        i_in_valid <= 1'b0;

        while (board.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("** eight_bit_minifloat_cpu_unit: PASSED **");
        end else begin
            $display("** eight_bit_minifloat_cpu_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ eight_bit_minifloat_cpu_unit.f @@
+incdir+hdl
hdl/emfc_pkg.sv
hdl/emfc_ram.sv
hdl/emfc_alu.sv
hdl/eight_bit_minifloat_cpu_unit.sv
tb/eight_bit_minifloat_cpu_unit_tb.sv
